@@ hw/rtl/ttse_pkg.sv @@
// Package for the tick trade signal engine: sizes, register codes and shared types.
// No dependencies; the other files that use it refer to it by scoped names.
package ttse_pkg;

  localparam int NUM_INSTRUMENTS   = 16;
  localparam int WINDOW_LEN        = 10;
  localparam int MIN_FOR_DEVIATION = 5;
  localparam int MOM_DEPTH         = 3;
  localparam int PCT_SCALE         = 100;

  localparam int INST_W   = 4;
  localparam int PRICE_W  = 22;
  localparam int DEV_W    = 6;
  localparam int OFFSET_W = 14;

  localparam int INST_AW = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
  localparam int PTR_W   = $clog2(WINDOW_LEN);
  localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W   = PRICE_W + PTR_W;

  localparam int RING_DEPTH = NUM_INSTRUMENTS * WINDOW_LEN;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int FACT_W   = $clog2(PCT_SCALE + (1 << DEV_W));
  localparam int CNT100_W = $clog2(WINDOW_LEN * PCT_SCALE + 1);

  localparam int APB_AW    = 4;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam int OBUF_AW    = 2;
  localparam int OBUF_DEPTH = 1 << OBUF_AW;
  localparam int OBUF_CW    = OBUF_AW + 1;
  localparam int OCC_W      = $clog2(OBUF_DEPTH + 3);

  localparam logic [PRICE_W-1:0]  LOW_THR_RST  = PRICE_W'(1050000);
  localparam logic [PRICE_W-1:0]  HIGH_THR_RST = PRICE_W'(1950000);
  localparam logic [DEV_W-1:0]    DEV_PCT_RST  = DEV_W'(2);
  localparam logic [OFFSET_W-1:0] OFFSET_RST   = OFFSET_W'(100);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOW_THR,
    REG_HIGH_THR,
    REG_DEV_PCT,
    REG_ORDER_OFS
  } reg_idx_t;

  typedef struct packed {
    logic [PRICE_W-1:0]  low_thr;
    logic [PRICE_W-1:0]  high_thr;
    logic [DEV_W-1:0]    dev_pct;
    logic [OFFSET_W-1:0] offset;
  } cfg_t;

  typedef struct packed {
    logic [PRICE_W-1:0] prev2;
    logic [PRICE_W-1:0] prev1;
    logic [CNT_W-1:0]   cnt;
    logic [SUM_W-1:0]   sum;
  } hist_rec_t;

  typedef struct packed {
    logic [INST_W-1:0]  inst;
    logic [PRICE_W-1:0] price;
    logic [CNT_W-1:0]   cnt;
    logic [SUM_W-1:0]   sum;
    logic               thr_hit;
    logic               mom_hit;
  } eval_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } hist_stat_t;

  typedef struct packed {
    logic [INST_W-1:0]  inst;
    logic [PRICE_W-1:0] price;
    logic               is_buy;
  } order_t;

endpackage

@@ hw/rtl/ttse_if.sv @@
// Channel interfaces of the tick trade signal engine: ticks in, orders out.
// Depends on ttse_pkg for field widths.
interface ttse_tick_if;
  logic                         valid;
  logic                         ready;
  logic [ttse_pkg::INST_W-1:0]  instrument;
  logic [ttse_pkg::PRICE_W-1:0] price;

  modport source (output valid, output instrument, output price, input ready);
  modport sink   (input valid, input instrument, input price, output ready);
endinterface

interface ttse_order_if;
  logic                         valid;
  logic                         ready;
  logic [ttse_pkg::INST_W-1:0]  order_instrument;
  logic [ttse_pkg::PRICE_W-1:0] order_price;
  logic                         is_buy;

  modport source (output valid, output order_instrument, output order_price, output is_buy,
                  input ready);
  modport sink   (input valid, input order_instrument, input order_price, input is_buy,
                  output ready);
endinterface

@@ hw/rtl/tick_trade_signal_engine_core.sv @@
// Accepted ticks pass the stage-1 and stage-2 registers, then orders enter the queue.
// Throughput: one tick per cycle; the per-instrument record RAM is read at accept and
// written back the next cycle, with the write-back record forwarded to a following tick.
// Input stalls only while the 4-entry order queue and the two stages hold 4 transactions.
// Reset (synchronous, rst_n low): clears pipeline, queue, ring pointers and record valid
// bits, loads register defaults; no clearing pass, ticks are accepted right after.
module tick_trade_signal_engine_core (
  input  logic                        clk,
  input  logic                        rst_n,
  ttse_tick_if.sink                   in_tick,
  ttse_order_if.source                out_order,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttse_pkg::APB_AW-1:0] paddr,
  input  logic [ttse_pkg::CFG_DW-1:0] pwdata,
  output logic [ttse_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  ttse_pkg::cfg_t                cfg;
  ttse_pkg::hist_stat_t          stat;
  ttse_pkg::eval_t               eval_q;
  ttse_pkg::order_t              order;
  logic                          push;
  logic [ttse_pkg::OBUF_CW-1:0]  level;
  logic [ttse_pkg::OCC_W-1:0]    occ;
  logic                          in_ready;
  logic                          in_range;
  logic                          tick_acc;

  assign occ      = ttse_pkg::OCC_W'(level) + ttse_pkg::OCC_W'(stat.s1_valid)
                  + ttse_pkg::OCC_W'(stat.s2_valid);
  assign in_ready = occ < ttse_pkg::OCC_W'(ttse_pkg::OBUF_DEPTH);
  assign in_range = 32'(in_tick.instrument) < ttse_pkg::NUM_INSTRUMENTS;
  assign tick_acc = in_tick.valid && in_ready && in_range;

  assign in_tick.ready = in_ready;

  ttse_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ttse_hist u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_acc   (tick_acc),
    .tick_inst  (in_tick.instrument),
    .tick_price (in_tick.price),
    .cfg        (cfg),
    .stat       (stat),
    .eval_q     (eval_q)
  );

  ttse_eval u_eval (
    .ev_valid (stat.s2_valid),
    .ev       (eval_q),
    .cfg      (cfg),
    .push     (push),
    .order    (order)
  );

  ttse_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (order),
    .level     (level),
    .out_order (out_order)
  );

endmodule

@@ hw/rtl/ttse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/ttse_cfg.sv @@
// APB-style configuration registers: thresholds, deviation band and order offset.
// Depends on ttse_pkg.
module ttse_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ttse_pkg::APB_AW-1:0]   paddr,
  input  logic [ttse_pkg::CFG_DW-1:0]   pwdata,
  output logic [ttse_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output ttse_pkg::cfg_t                cfg
);

  logic [ttse_pkg::PRICE_W-1:0]  low_thr_r;
  logic [ttse_pkg::PRICE_W-1:0]  high_thr_r;
  logic [ttse_pkg::DEV_W-1:0]    dev_pct_r;
  logic [ttse_pkg::OFFSET_W-1:0] offset_r;
  ttse_pkg::reg_idx_t            reg_idx;
  logic                          wr_en;

  assign reg_idx = ttse_pkg::reg_idx_t'(paddr[ttse_pkg::APB_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= ttse_pkg::LOW_THR_RST;
      high_thr_r <= ttse_pkg::HIGH_THR_RST;
      dev_pct_r  <= ttse_pkg::DEV_PCT_RST;
      offset_r   <= ttse_pkg::OFFSET_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ttse_pkg::REG_LOW_THR:   low_thr_r  <= pwdata[ttse_pkg::PRICE_W-1:0];
        ttse_pkg::REG_HIGH_THR:  high_thr_r <= pwdata[ttse_pkg::PRICE_W-1:0];
        ttse_pkg::REG_DEV_PCT:   dev_pct_r  <= pwdata[ttse_pkg::DEV_W-1:0];
        ttse_pkg::REG_ORDER_OFS: offset_r   <= pwdata[ttse_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ttse_pkg::REG_LOW_THR:   prdata = ttse_pkg::CFG_DW'(low_thr_r);
      ttse_pkg::REG_HIGH_THR:  prdata = ttse_pkg::CFG_DW'(high_thr_r);
      ttse_pkg::REG_DEV_PCT:   prdata = ttse_pkg::CFG_DW'(dev_pct_r);
      ttse_pkg::REG_ORDER_OFS: prdata = ttse_pkg::CFG_DW'(offset_r);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.low_thr  = low_thr_r;
  assign cfg.high_thr = high_thr_r;
  assign cfg.dev_pct  = dev_pct_r;
  assign cfg.offset   = offset_r;

endmodule

@@ hw/rtl/ttse_hist.sv @@
// Per-instrument history: price ring RAM and record RAM (sum, count, last two prices),
// read at accept, updated and written back the next cycle. Depends on ttse_pkg, ttse_ram.
module ttse_hist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick_acc,
  input  logic [ttse_pkg::INST_W-1:0]  tick_inst,
  input  logic [ttse_pkg::PRICE_W-1:0] tick_price,
  input  ttse_pkg::cfg_t               cfg,
  output ttse_pkg::hist_stat_t         stat,
  output ttse_pkg::eval_t              eval_q
);

  localparam int REC_W = $bits(ttse_pkg::hist_rec_t);

  function automatic logic [ttse_pkg::RING_AW-1:0] ring_addr(
    input logic [ttse_pkg::INST_AW-1:0] inst,
    input logic [ttse_pkg::PTR_W-1:0]   ptr
  );
    ring_addr = ttse_pkg::RING_AW'(inst) * ttse_pkg::RING_AW'(ttse_pkg::WINDOW_LEN)
              + ttse_pkg::RING_AW'(ptr);
  endfunction

  logic [ttse_pkg::PTR_W-1:0]      ptr_r [ttse_pkg::NUM_INSTRUMENTS];
  logic [ttse_pkg::NUM_INSTRUMENTS-1:0] vld_r;

  logic                            s1_valid_r;
  logic [ttse_pkg::INST_W-1:0]     s1_inst_r;
  logic [ttse_pkg::PRICE_W-1:0]    s1_price_r;
  logic [ttse_pkg::PTR_W-1:0]      s1_ptr_r;
  logic                            s1_fwd_r;
  logic                            s1_vld_r;
  ttse_pkg::hist_rec_t             fwd_rec_r;

  logic                            s2_valid_r;
  ttse_pkg::eval_t                 eval_r;

  logic [ttse_pkg::INST_AW-1:0]    rd_inst;
  logic [ttse_pkg::INST_AW-1:0]    s1_addr;
  logic                            same_inst;
  logic [ttse_pkg::PTR_W-1:0]      s1_ptr_inc;
  logic [ttse_pkg::PTR_W-1:0]      ptr_rd;
  logic [REC_W-1:0]                st_rdata;
  logic [ttse_pkg::PRICE_W-1:0]    evict_price;
  ttse_pkg::hist_rec_t             rec_cur;
  ttse_pkg::hist_rec_t             rec_nxt;
  logic                            full;
  logic                            mom_hit;
  logic                            thr_hit;

  assign rd_inst    = ttse_pkg::INST_AW'(tick_inst);
  assign s1_addr    = ttse_pkg::INST_AW'(s1_inst_r);
  assign same_inst  = s1_valid_r && (s1_inst_r == tick_inst);
  assign s1_ptr_inc = (s1_ptr_r == ttse_pkg::PTR_W'(ttse_pkg::WINDOW_LEN - 1)) ?
                      '0 : s1_ptr_r + 1'b1;
  assign ptr_rd     = same_inst ? s1_ptr_inc : ptr_r[rd_inst];

  ttse_ram #(.WIDTH(REC_W), .DEPTH(ttse_pkg::NUM_INSTRUMENTS)) u_rec_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr),
    .wdata (REC_W'(rec_nxt)),
    .raddr (rd_inst),
    .rdata (st_rdata)
  );

  ttse_ram #(.WIDTH(ttse_pkg::PRICE_W), .DEPTH(ttse_pkg::RING_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (ring_addr(s1_addr, s1_ptr_r)),
    .wdata (s1_price_r),
    .raddr (ring_addr(rd_inst, ptr_rd)),
    .rdata (evict_price)
  );

  // forward the record written back in the same cycle as the read; then update it and test the hits
  always_comb begin
    if (s1_fwd_r) begin
      rec_cur = fwd_rec_r;
    end else if (s1_vld_r) begin
      rec_cur = ttse_pkg::hist_rec_t'(st_rdata);
    end else begin
      rec_cur = '0;
    end
    full          = rec_cur.cnt >= ttse_pkg::CNT_W'(ttse_pkg::WINDOW_LEN);
    rec_nxt.cnt   = full ? ttse_pkg::CNT_W'(ttse_pkg::WINDOW_LEN) : rec_cur.cnt + 1'b1;
    rec_nxt.sum   = rec_cur.sum - (full ? ttse_pkg::SUM_W'(evict_price) : '0)
                  + ttse_pkg::SUM_W'(s1_price_r);
    rec_nxt.prev1 = s1_price_r;
    rec_nxt.prev2 = rec_cur.prev1;
    mom_hit       = (rec_nxt.cnt >= ttse_pkg::CNT_W'(ttse_pkg::MOM_DEPTH))
                  && (rec_cur.prev1 > rec_cur.prev2) && (s1_price_r > rec_cur.prev1);
    thr_hit       = (s1_price_r < cfg.low_thr) || (s1_price_r > cfg.high_thr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      vld_r      <= '0;
      for (int i = 0; i < ttse_pkg::NUM_INSTRUMENTS; i++) begin
        ptr_r[i] <= '0;
      end
    end else begin
      s1_valid_r <= tick_acc;
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        ptr_r[s1_addr] <= s1_ptr_inc;
        vld_r[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_inst_r  <= tick_inst;
      s1_price_r <= tick_price;
      s1_ptr_r   <= ptr_rd;
      s1_fwd_r   <= same_inst;
      s1_vld_r   <= vld_r[rd_inst];
      fwd_rec_r  <= rec_nxt;
    end
    eval_r.inst    <= s1_inst_r;
    eval_r.price   <= s1_price_r;
    eval_r.cnt     <= rec_nxt.cnt;
    eval_r.sum     <= rec_nxt.sum;
    eval_r.thr_hit <= thr_hit;
    eval_r.mom_hit <= mom_hit;
  end

  assign stat.s1_valid = s1_valid_r;
  assign stat.s2_valid = s2_valid_r;
  assign eval_q        = eval_r;

endmodule

@@ hw/rtl/ttse_eval.sv @@
// Signal evaluation: cross-multiplied deviation test, buy/sell decision, order price.
// Depends on ttse_pkg.
module ttse_eval (
  input  logic            ev_valid,
  input  ttse_pkg::eval_t ev,
  input  ttse_pkg::cfg_t  cfg,
  output logic            push,
  output ttse_pkg::order_t order
);

  localparam int LHS_W  = ttse_pkg::PRICE_W + ttse_pkg::CNT100_W;
  localparam int BAND_W = ttse_pkg::SUM_W + ttse_pkg::FACT_W;
  localparam int PC_W   = ttse_pkg::PRICE_W + ttse_pkg::CNT_W;

  logic [ttse_pkg::FACT_W-1:0]   lo_f;
  logic [ttse_pkg::FACT_W-1:0]   hi_f;
  logic [ttse_pkg::CNT100_W-1:0] cnt100;
  logic [LHS_W-1:0]              lhs;
  logic [BAND_W-1:0]             band_lo;
  logic [BAND_W-1:0]             band_hi;
  logic [PC_W-1:0]               price_cnt;
  logic                          dev_en;
  logic                          dev_hit;
  logic                          below;
  logic                          buy;
  logic                          sell;
  logic [ttse_pkg::PRICE_W:0]    price_up;
  logic [ttse_pkg::PRICE_W-1:0]  ofs;

  assign lo_f      = ttse_pkg::FACT_W'(ttse_pkg::PCT_SCALE) - ttse_pkg::FACT_W'(cfg.dev_pct);
  assign hi_f      = ttse_pkg::FACT_W'(ttse_pkg::PCT_SCALE) + ttse_pkg::FACT_W'(cfg.dev_pct);
  assign cnt100    = ttse_pkg::CNT100_W'(ev.cnt) * ttse_pkg::CNT100_W'(ttse_pkg::PCT_SCALE);
  assign lhs       = ev.price * cnt100;
  assign band_lo   = ev.sum * lo_f;
  assign band_hi   = ev.sum * hi_f;
  assign price_cnt = ev.price * ev.cnt;

  assign dev_en  = (ttse_pkg::MIN_FOR_DEVIATION <= ttse_pkg::WINDOW_LEN)
                && (ev.cnt >= ttse_pkg::CNT_W'(ttse_pkg::MIN_FOR_DEVIATION));
  assign dev_hit = dev_en && ((lhs < band_lo) || (lhs > band_hi));
  assign below   = price_cnt < ev.sum;
  assign buy     = ev.thr_hit || ev.mom_hit || (dev_hit && below);
  assign sell    = dev_hit && !below;

  assign ofs      = ttse_pkg::PRICE_W'(cfg.offset);
  assign price_up = ev.price + ofs;

  always_comb begin
    order.inst   = ev.inst;
    order.is_buy = buy;
    if (buy) begin
      order.price = price_up[ttse_pkg::PRICE_W] ? '1 : price_up[ttse_pkg::PRICE_W-1:0];
    end else begin
      order.price = (ev.price > ofs) ? ev.price - ofs : '0;
    end
  end

  assign push = ev_valid && (buy || sell);

endmodule

@@ hw/rtl/ttse_obuf.sv @@
// Output queue of orders; drives the order channel and reports its fill level.
// Depends on ttse_pkg and ttse_order_if.
module ttse_obuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  ttse_pkg::order_t              din,
  output logic [ttse_pkg::OBUF_CW-1:0]  level,
  ttse_order_if.source                  out_order
);

  ttse_pkg::order_t               mem_r [ttse_pkg::OBUF_DEPTH];
  logic [ttse_pkg::OBUF_AW-1:0]   wr_ptr_r;
  logic [ttse_pkg::OBUF_AW-1:0]   rd_ptr_r;
  logic [ttse_pkg::OBUF_CW-1:0]   cnt_r;
  logic [ttse_pkg::OBUF_CW-1:0]   cnt_nxt;
  logic                           pop;
  ttse_pkg::order_t               head;

  assign pop     = out_order.valid && out_order.ready;
  assign cnt_nxt = cnt_r + ttse_pkg::OBUF_CW'(push) - ttse_pkg::OBUF_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign head                       = mem_r[rd_ptr_r];
  assign out_order.valid            = cnt_r != '0;
  assign out_order.order_instrument = head.inst;
  assign out_order.order_price      = head.price;
  assign out_order.is_buy           = head.is_buy;
  assign level                      = cnt_r;

endmodule

@@ hw/rtl/ttse_checker.sv @@
// Port-level checks of the tick trade signal engine, bound to the top level.
// Depends on ttse_pkg and tick_trade_signal_engine_core.
module ttse_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ttse_pkg::INST_W-1:0]  out_inst,
  input logic [ttse_pkg::PRICE_W-1:0] out_price,
  input logic                         out_is_buy
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("order pending or input blocked after reset");

  a_first_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 3))
    else $error("order from empty queue without a tick three cycles earlier");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input blocked without a stalled order");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_inst) && $stable(out_price) && $stable(out_is_buy)))
    else $error("stalled order changed or dropped");

endmodule

bind tick_trade_signal_engine_core ttse_checker u_ttse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_tick.valid),
  .in_ready   (in_tick.ready),
  .out_valid  (out_order.valid),
  .out_ready  (out_order.ready),
  .out_inst   (out_order.order_instrument),
  .out_price  (out_order.order_price),
  .out_is_buy (out_order.is_buy)
);

@@ tb/sv/tick_trade_signal_engine_core_tb.sv @@
// Testbench for tick_trade_signal_engine_core: directed and random tick traffic, with
// orders checked field by field against a per-instrument price history kept here.
// Depends on ttse_pkg, ttse_tick_if and ttse_order_if from hw/rtl.
module tick_trade_signal_engine_core_tb;

  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int EXP_DEPTH    = 64;
  localparam logic [ttse_pkg::PRICE_W-1:0] PRICE_MAX = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ttse_pkg::APB_AW-1:0] paddr;
  logic [ttse_pkg::CFG_DW-1:0] pwdata;
  logic [ttse_pkg::CFG_DW-1:0] prdata;
  logic pready;

  ttse_tick_if  tick_ch ();
  ttse_order_if order_ch ();

  tick_trade_signal_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tick   (tick_ch),
    .out_order (order_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // Configuration and history as the block should hold them
  logic [ttse_pkg::PRICE_W-1:0]  cfg_low;
  logic [ttse_pkg::PRICE_W-1:0]  cfg_high;
  logic [ttse_pkg::DEV_W-1:0]    cfg_dev;
  logic [ttse_pkg::OFFSET_W-1:0] cfg_ofs;

  logic [ttse_pkg::PRICE_W-1:0] price_hist [ttse_pkg::NUM_INSTRUMENTS][ttse_pkg::WINDOW_LEN];
  longint unsigned    hist_sum [ttse_pkg::NUM_INSTRUMENTS];
  int unsigned        hist_cnt [ttse_pkg::NUM_INSTRUMENTS];
  int unsigned        hist_ptr [ttse_pkg::NUM_INSTRUMENTS];

  ttse_pkg::order_t exp_fifo [EXP_DEPTH];
  int               exp_head = 0;
  int               exp_tail = 0;
  int               exp_count = 0;
  int               market_level [ttse_pkg::NUM_INSTRUMENTS];

  int mismatches;
  int ticks_sent;
  int orders_seen;
  int settings_used;
  int burst_left;
  int idle_cycles = 0;

  function automatic void store_order(input ttse_pkg::order_t ord);
    if (exp_count == EXP_DEPTH) begin
      $error("expected order store full, order dropped");
      mismatches++;
    end else begin
      exp_fifo[exp_tail] = ord;
      exp_tail = (exp_tail + 1) % EXP_DEPTH;
      exp_count++;
    end
  endfunction

  function automatic bit predict_order(input logic [ttse_pkg::INST_W-1:0] inst,
                                       input logic [ttse_pkg::PRICE_W-1:0] px,
                                       output ttse_pkg::order_t ord);
    int unsigned slot;
    int unsigned cnt;
    longint unsigned sum;
    longint unsigned p;
    longint unsigned lhs;
    longint unsigned lo_f;
    longint unsigned hi_f;
    longint unsigned oprice;
    logic [ttse_pkg::PRICE_W-1:0] p1, p2, p3;
    bit buy;
    bit sell;
    p = px;
    buy = 1'b0;
    sell = 1'b0;
    ord = '0;
    slot = hist_ptr[inst];
    cnt = hist_cnt[inst];
    sum = hist_sum[inst];
    if (cnt >= ttse_pkg::WINDOW_LEN) begin
      sum -= price_hist[inst][slot];
    end else begin
      cnt++;
    end
    sum += p;
    price_hist[inst][slot] = px;
    slot = (slot + 1) % ttse_pkg::WINDOW_LEN;
    hist_ptr[inst] = slot;
    hist_cnt[inst] = cnt;
    hist_sum[inst] = sum;

    if (px < cfg_low || px > cfg_high) buy = 1'b1;

    if (cnt >= ttse_pkg::MIN_FOR_DEVIATION) begin
      lhs  = p * cnt * ttse_pkg::PCT_SCALE;
      lo_f = (cfg_dev > ttse_pkg::PCT_SCALE) ? 0 : ttse_pkg::PCT_SCALE - cfg_dev;
      hi_f = ttse_pkg::PCT_SCALE + cfg_dev;
      if (lhs < sum * lo_f || lhs > sum * hi_f) begin
        if (p * cnt < sum) buy = 1'b1;
        else sell = 1'b1;
      end
    end

    if (cnt >= ttse_pkg::MOM_DEPTH) begin
      p1 = price_hist[inst][(slot + ttse_pkg::WINDOW_LEN - 1) % ttse_pkg::WINDOW_LEN];
      p2 = price_hist[inst][(slot + ttse_pkg::WINDOW_LEN - 2) % ttse_pkg::WINDOW_LEN];
      p3 = price_hist[inst][(slot + ttse_pkg::WINDOW_LEN - 3) % ttse_pkg::WINDOW_LEN];
      if (p2 > p3 && p1 > p2) buy = 1'b1;
    end

    if (!buy && !sell) return 1'b0;

    if (buy) begin
      oprice = p + cfg_ofs;
      if (oprice > PRICE_MAX) oprice = PRICE_MAX;
    end else begin
      oprice = (p > cfg_ofs) ? p - cfg_ofs : 0;
    end
    ord.inst   = inst;
    ord.price  = oprice[ttse_pkg::PRICE_W-1:0];
    ord.is_buy = buy;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_tick(input logic [ttse_pkg::INST_W-1:0] inst,
                           input logic [ttse_pkg::PRICE_W-1:0] px);
    ttse_pkg::order_t ord;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        tick_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.instrument <= inst;
    tick_ch.price      <= px;
    do @(posedge clk); while (!tick_ch.ready);
    burst_left--;
    ticks_sent++;
    if (predict_order(inst, px, ord)) store_order(ord);
  endtask

  task automatic wait_quiet;
    tick_ch.valid <= 1'b0;
    while (exp_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it back; psel stays high for the next transfer
  task automatic reg_access(input ttse_pkg::reg_idx_t idx,
                            input logic [ttse_pkg::CFG_DW-1:0] data);
    logic [ttse_pkg::CFG_DW-1:0] keep;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ttse_pkg::APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      ttse_pkg::REG_LOW_THR: begin
        cfg_low = data[ttse_pkg::PRICE_W-1:0];
        keep = ttse_pkg::CFG_DW'(cfg_low);
      end
      ttse_pkg::REG_HIGH_THR: begin
        cfg_high = data[ttse_pkg::PRICE_W-1:0];
        keep = ttse_pkg::CFG_DW'(cfg_high);
      end
      ttse_pkg::REG_DEV_PCT: begin
        cfg_dev = data[ttse_pkg::DEV_W-1:0];
        keep = ttse_pkg::CFG_DW'(cfg_dev);
      end
      default: begin
        cfg_ofs = data[ttse_pkg::OFFSET_W-1:0];
        keep = ttse_pkg::CFG_DW'(cfg_ofs);
      end
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field(idx.name(), keep, prdata);
  endtask

  task automatic configure(input logic [ttse_pkg::PRICE_W-1:0] lo,
                           input logic [ttse_pkg::PRICE_W-1:0] hi,
                           input logic [ttse_pkg::DEV_W-1:0] dev,
                           input logic [ttse_pkg::OFFSET_W-1:0] ofs,
                           input bit junk);
    logic [ttse_pkg::CFG_DW-1:0] fill;
    fill = junk ? $urandom() : '0;
    reg_access(ttse_pkg::REG_LOW_THR,   {fill[ttse_pkg::CFG_DW-1:ttse_pkg::PRICE_W], lo});
    reg_access(ttse_pkg::REG_HIGH_THR,  {fill[ttse_pkg::CFG_DW-1:ttse_pkg::PRICE_W], hi});
    reg_access(ttse_pkg::REG_DEV_PCT,   {fill[ttse_pkg::CFG_DW-1:ttse_pkg::DEV_W], dev});
    reg_access(ttse_pkg::REG_ORDER_OFS, {fill[ttse_pkg::CFG_DW-1:ttse_pkg::OFFSET_W], ofs});
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  task automatic test_threshold_edges;
    send_tick(0, 0);
    send_tick(0, PRICE_MAX);
    send_tick(0, ttse_pkg::LOW_THR_RST);
    send_tick(0, ttse_pkg::HIGH_THR_RST);
    send_tick(15, ttse_pkg::LOW_THR_RST - 1);
    send_tick(15, ttse_pkg::HIGH_THR_RST + 1);
    wait_quiet();
  endtask

  task automatic test_momentum;
    send_tick(3, 1200000);
    send_tick(3, 1200001);
    send_tick(3, 1200002);
    send_tick(3, 1200002);
    wait_quiet();
  endtask

  task automatic test_deviation;
    repeat (4) send_tick(5, 1500000);
    send_tick(5, 1600000);
    send_tick(5, 1400000);
    wait_quiet();
  endtask

  task automatic test_sell_underflow;
    configure(0, PRICE_MAX, ttse_pkg::DEV_PCT_RST, ttse_pkg::OFFSET_RST, 1'b0);
    repeat (4) send_tick(7, 0);
    send_tick(7, 50);
    wait_quiet();
  endtask

  // Random walk per instrument with rising runs, jumps and raw noise mixed in
  task automatic run_market(input int n_items);
    logic [ttse_pkg::INST_W-1:0]  focus [4];
    logic [ttse_pkg::INST_W-1:0]  inst;
    logic [ttse_pkg::PRICE_W-1:0] px;
    int kind;
    int step;
    int lvl;
    foreach (focus[k]) begin
      focus[k] = ttse_pkg::INST_W'($urandom_range(0, ttse_pkg::NUM_INSTRUMENTS - 1));
      if ($urandom_range(0, 3) == 0) market_level[focus[k]] = $urandom_range(0, PRICE_MAX);
    end
    repeat (n_items) begin
      if ($urandom_range(0, 3) != 0) begin
        inst = focus[$urandom_range(0, 3)];
      end else begin
        inst = ttse_pkg::INST_W'($urandom_range(0, ttse_pkg::NUM_INSTRUMENTS - 1));
      end
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        px = ttse_pkg::PRICE_W'($urandom_range(0, PRICE_MAX));
      end else begin
        if (kind < 60) begin
          step = int'($urandom_range(0, 4000)) - 2000;
        end else if (kind < 75) begin
          step = $urandom_range(1, 800);
        end else begin
          step = market_level[inst] / 100 * int'($urandom_range(3, 12));
          if ($urandom_range(0, 1)) step = -step;
        end
        lvl = market_level[inst] + step;
        if (lvl < 0) lvl = 0;
        if (lvl > PRICE_MAX) lvl = PRICE_MAX;
        market_level[inst] = lvl;
        px = ttse_pkg::PRICE_W'(lvl);
      end
      send_tick(inst, px);
    end
    wait_quiet();
  endtask

  task automatic test_config_sweep;
    configure(ttse_pkg::LOW_THR_RST, ttse_pkg::HIGH_THR_RST, ttse_pkg::DEV_PCT_RST,
              ttse_pkg::OFFSET_RST, 1'b0);
    run_market(150);
    configure(0, PRICE_MAX, 0, 0, 1'b1);
    run_market(150);
    configure(PRICE_MAX, 0, '1, '1, 1'b0);
    run_market(140);
    configure(0, PRICE_MAX, '1, '1, 1'b1);
    run_market(150);
    repeat (2) begin
      configure(ttse_pkg::PRICE_W'($urandom_range(0, 2000000)),
                ttse_pkg::PRICE_W'($urandom_range(1500000, PRICE_MAX)),
                ttse_pkg::DEV_W'($urandom_range(0, 63)),
                ttse_pkg::OFFSET_W'($urandom_range(0, 16383)), 1'b1);
      run_market(140);
    end
  endtask

  // Receiver: ready follows a mode, redrawn at random: always ready, random, or one of two fixed patterns
  initial begin
    int mode;
    int mode_left;
    int cyc;
    mode_left = 0;
    cyc = 0;
    order_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      cyc++;
      case (mode)
        0: order_ch.ready <= 1'b1;
        1: order_ch.ready <= 1'($urandom_range(0, 1));
        2: order_ch.ready <= (cyc % 16) < 10;
        default: order_ch.ready <= (cyc % 4) == 0;
      endcase
    end
  end

  always @(posedge clk) begin
    ttse_pkg::order_t want;
    if (rst_n && order_ch.valid && order_ch.ready) begin
      orders_seen++;
      if (exp_count == 0) begin
        $error("unexpected order: instrument %0d, price %0d, is_buy %0d",
               order_ch.order_instrument, order_ch.order_price, order_ch.is_buy);
        mismatches++;
      end else begin
        want = exp_fifo[exp_head];
        exp_head = (exp_head + 1) % EXP_DEPTH;
        exp_count--;
        check_field("order_instrument", want.inst, order_ch.order_instrument);
        check_field("order_price", want.price, order_ch.order_price);
        check_field("is_buy", want.is_buy, order_ch.is_buy);
      end
    end
  end

  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (order_ch.valid && order_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAIL tick_trade_signal_engine_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches    = 0;
    ticks_sent    = 0;
    orders_seen   = 0;
    settings_used = 0;
    burst_left    = 0;
    cfg_low  = ttse_pkg::LOW_THR_RST;
    cfg_high = ttse_pkg::HIGH_THR_RST;
    cfg_dev  = ttse_pkg::DEV_PCT_RST;
    cfg_ofs  = ttse_pkg::OFFSET_RST;
    for (int i = 0; i < ttse_pkg::NUM_INSTRUMENTS; i++) begin
      hist_sum[i] = 0;
      hist_cnt[i] = 0;
      hist_ptr[i] = 0;
      market_level[i] = $urandom_range(1100000, 1900000);
      for (int j = 0; j < ttse_pkg::WINDOW_LEN; j++) price_hist[i][j] = '0;
    end
    rst_n              <= 1'b0;
    tick_ch.valid      <= 1'b0;
    tick_ch.instrument <= '0;
    tick_ch.price      <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_threshold_edges();
    test_momentum();
    test_deviation();
    test_sell_underflow();
    test_config_sweep();

    $display("Sent %0d ticks over %0d register settings; %0d orders compared, %0d mismatches",
             ticks_sent, settings_used, orders_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS tick_trade_signal_engine_core");
    end else begin
      $display("FAIL tick_trade_signal_engine_core");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ttse_pkg.sv
hw/rtl/ttse_if.sv
hw/rtl/ttse_ram.sv
hw/rtl/ttse_cfg.sv
hw/rtl/ttse_hist.sv
hw/rtl/ttse_eval.sv
hw/rtl/ttse_obuf.sv
hw/rtl/tick_trade_signal_engine_core.sv
hw/rtl/ttse_checker.sv
tb/sv/tick_trade_signal_engine_core_tb.sv
